// File: rtl/core/apuel_pkg.sv
// Package for the sound-register envelope and length-counter unit.
// Holds the beat structs, control structs, offsets and the length table.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package apuel_pkg;

   // Kinds of input beat.
   typedef enum logic [1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_QUARTER = 2'd2,
      FUNC_HALF    = 2'd3
   } apuel_func_type;

   // Register offsets from the sound block base.
   localparam logic [4:0] OFF_PA_CTRL  = 5'h00;
   localparam logic [4:0] OFF_PA_LEN   = 5'h03;
   localparam logic [4:0] OFF_PB_CTRL  = 5'h04;
   localparam logic [4:0] OFF_PB_LEN   = 5'h07;
   localparam logic [4:0] OFF_TRI_LIN  = 5'h08;
   localparam logic [4:0] OFF_TRI_LEN  = 5'h0B;
   localparam logic [4:0] OFF_NS_CTRL  = 5'h0C;
   localparam logic [4:0] OFF_NS_LEN   = 5'h0F;
   localparam logic [4:0] OFF_LAST_CH  = 5'h13;
   localparam logic [4:0] OFF_STATUS   = 5'h15;
   localparam logic [4:0] OFF_FRAME    = 5'h17;

   localparam int unsigned NUM_REGS = 24;
   localparam int unsigned NUM_LEN  = 4;
   localparam int unsigned NUM_ENV  = 3;

   // Length counter indexes.
   localparam int unsigned CH_PA  = 0;
   localparam int unsigned CH_PB  = 1;
   localparam int unsigned CH_TRI = 2;
   localparam int unsigned CH_NS  = 3;

   // Length counter load values, indexed by bits 7..3 of the written byte.
   localparam logic [7:0] LEN_TABLE [32] = '{
      8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
      8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
      8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
      8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
   };

   // Input beat.
   typedef struct packed {
      logic [1:0] func;
      logic [4:0] reg_offset;
      logic [7:0] wdata;
   } apuel_req_type;

   // Result beat.
   typedef struct packed {
      logic [7:0] rdata;
      logic [3:0] pulse_a_level;
      logic [3:0] pulse_b_level;
      logic [3:0] noise_level;
      logic [3:0] active_flags;
      logic [7:0] triangle_linear;
   } apuel_rsp_type;

   // Per-envelope control for one beat.
   typedef struct packed {
      logic ctrl_wr;   // write of the channel's control register
      logic restart;   // length write that restarts the envelope
      logic quarter;   // quarter-frame tick
   } apuel_env_ctl_type;

   // Length and linear counter control for one beat.
   typedef struct packed {
      logic [3:0] load;        // length write per channel
      logic [7:0] load_val;    // table value for the written byte
      logic       status_wr;   // write of the enable register
      logic [4:0] status_val;
      logic       half;        // half-frame tick
      logic [3:0] halt;        // length halt per channel
      logic       tri_ctrl;    // triangle control bit
      logic [6:0] lin_reload;  // triangle linear reload field
      logic       lin_set;     // write of the triangle length register
   } apuel_len_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/apuel_env.sv
// One volume envelope: divider, level and running flag.
// Depends on apuel_pkg for the control struct.
`default_nettype none

module apuel_env
   import apuel_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        ctrl_reg,   // control register after this beat's write
   input  wire apuel_env_ctl_type ctl,
   output logic [3:0]             level_out
);

   logic [3:0] level_ff, level_in;
   logic [3:0] div_ff, div_in;
   logic       run_ff, run_in;
   logic       const_vol;
   logic       loop_en;
   logic [3:0] level_dec;

   assign const_vol = ctrl_reg[4];
   assign loop_en   = ctrl_reg[5];
   assign level_dec = (level_ff != 4'd0) ? level_ff - 4'd1 : 4'd0;

   // Restart, stop or step the envelope.
   always_comb begin
      level_in = level_ff;
      div_in   = div_ff;
      run_in   = run_ff;
      if (ctl.ctrl_wr && const_vol) begin
         level_in = 4'd0;
         div_in   = 4'd0;
         run_in   = 1'b0;
      end else if (ctl.ctrl_wr || ctl.restart) begin
         level_in = 4'd15;
         div_in   = ctrl_reg[3:0];
         run_in   = 1'b1;
      end else if (ctl.quarter && run_ff && !const_vol &&
                   !(level_ff == 4'd0 && !loop_en)) begin
         if (div_ff != 4'd0) begin
            div_in = div_ff - 4'd1;
         end else begin
            div_in   = ctrl_reg[3:0];
            level_in = (level_dec == 4'd0 && loop_en) ? 4'd15 : level_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 4'd0;
         div_ff   <= 4'd0;
         run_ff   <= 1'b0;
      end else begin
         level_ff <= level_in;
         div_ff   <= div_in;
         run_ff   <= run_in;
      end
   end

   // Constant volume shows the register field, otherwise the new level.
   assign level_out = const_vol ? ctrl_reg[3:0] : level_in;

endmodule

`default_nettype wire

// File: rtl/core/apuel_len.sv
// Length counters, channel enables and the triangle linear counter.
// Depends on apuel_pkg for the control struct and channel indexes.
`default_nettype none

module apuel_len
   import apuel_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire apuel_len_ctl_type ctl,
   output logic [4:0]             enables,
   output logic [3:0]             active_flags,
   output logic [7:0]             linear
);

   logic [7:0] len_ff [NUM_LEN];
   logic [7:0] len_in [NUM_LEN];
   logic [4:0] en_ff, en_in;
   logic [7:0] lin_ff, lin_in;
   logic       pend_ff, pend_in;

   // Length counters: load, clear on disable, count down on half ticks.
   always_comb begin
      for (int ch = 0; ch < NUM_LEN; ch++) begin
         len_in[ch] = len_ff[ch];
         if (ctl.load[ch] && en_ff[ch]) begin
            len_in[ch] = ctl.load_val;
         end
         if (ctl.status_wr && !ctl.status_val[ch]) begin
            len_in[ch] = 8'd0;
         end
         if (ctl.half && len_ff[ch] != 8'd0 && !ctl.halt[ch]) begin
            len_in[ch] = len_ff[ch] - 8'd1;
         end
      end
      en_in = ctl.status_wr ? ctl.status_val : en_ff;
   end

   // Linear counter: reload while requested, otherwise count down.
   always_comb begin
      lin_in  = lin_ff;
      pend_in = pend_ff;
      if (ctl.lin_set) begin
         pend_in = 1'b1;
      end
      if (ctl.half) begin
         if (pend_ff) begin
            lin_in = {1'b0, ctl.lin_reload} + 8'd1;
         end else if (lin_ff != 8'd0) begin
            lin_in = lin_ff - 8'd1;
         end
         if (!ctl.tri_ctrl) begin
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < NUM_LEN; ch++) begin
            len_ff[ch] <= 8'd0;
         end
         en_ff   <= 5'd0;
         lin_ff  <= 8'd0;
         pend_ff <= 1'b0;
      end else begin
         for (int ch = 0; ch < NUM_LEN; ch++) begin
            len_ff[ch] <= len_in[ch];
         end
         en_ff   <= en_in;
         lin_ff  <= lin_in;
         pend_ff <= pend_in;
      end
   end

   assign enables = en_ff;
   assign linear  = lin_in;
   assign active_flags = {
      len_in[CH_NS] != 8'd0,
      (len_in[CH_TRI] != 8'd0) && (lin_in != 8'd0),
      len_in[CH_PB] != 8'd0,
      len_in[CH_PA] != 8'd0
   };

endmodule

`default_nettype wire

// File: rtl/core/apu_register_envelope_length_unit.sv
// Top level of the sound-register envelope and length-counter unit.
// Depends on apuel_pkg, apuel_env and apuel_len.
//
// The unit takes one beat in every clock cycle: busy is always low, so a
// beat is accepted at each edge where start is high. The beat is held in
// an input register, and in the next cycle the register file, the three
// envelopes and the length and linear counters are updated together and
// the result is loaded into the output register, from which it drives
// rsp_valid/rsp_data. It is held for exactly one cycle, in the order the
// beats came in; the receiver must take it then.
// The valid flags, register file, envelopes and counters reset to zero,
// with no clearing pass; the input and result data registers are not reset.
`default_nettype none

module apu_register_envelope_length_unit
   import apuel_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire apuel_req_type req_data,
   output logic               rsp_valid,
   output apuel_rsp_type      rsp_data
);

   apuel_req_type     req_ff;
   logic              req_vld_ff;
   logic [7:0]        regs_ff [NUM_REGS];
   logic [7:0]        regs_in [NUM_REGS];
   apuel_rsp_type     rsp_ff, rsp_in;
   logic              rsp_vld_ff;
   logic              is_wr, is_rd, is_quarter, is_half, mapped;
   logic [4:0]        off;
   logic [7:0]        wdata;
   logic [4:0]        enables;
   apuel_env_ctl_type env_ctl [NUM_ENV];
   apuel_len_ctl_type len_ctl;
   logic [3:0]        env_level [NUM_ENV];
   logic [3:0]        active_flags;
   logic [7:0]        linear;

   assign busy = 1'b0;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start && !busy;
      end
      req_ff <= req_data;
   end

   // Beat decode.
   assign off        = req_ff.reg_offset;
   assign wdata      = req_ff.wdata;
   assign mapped     = (off <= OFF_LAST_CH) || (off == OFF_STATUS) || (off == OFF_FRAME);
   assign is_wr      = req_vld_ff && (req_ff.func == FUNC_WRITE) && mapped;
   assign is_rd      = req_vld_ff && (req_ff.func == FUNC_READ) && mapped;
   assign is_quarter = req_vld_ff && (req_ff.func == FUNC_QUARTER);
   assign is_half    = req_vld_ff && (req_ff.func == FUNC_HALF);

   // Register copies after this beat's write.
   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         regs_in[i] = regs_ff[i];
      end
      if (is_wr) begin
         regs_in[off] = wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= 8'd0;
         end
      end else begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= regs_in[i];
         end
      end
   end

   // Envelope control: a length write restarts an enabled channel that is
   // not in constant-volume mode.
   always_comb begin
      env_ctl[0].ctrl_wr = is_wr && (off == OFF_PA_CTRL);
      env_ctl[1].ctrl_wr = is_wr && (off == OFF_PB_CTRL);
      env_ctl[2].ctrl_wr = is_wr && (off == OFF_NS_CTRL);
      env_ctl[0].restart = is_wr && (off == OFF_PA_LEN) && enables[CH_PA] &&
                           !regs_ff[OFF_PA_CTRL][4];
      env_ctl[1].restart = is_wr && (off == OFF_PB_LEN) && enables[CH_PB] &&
                           !regs_ff[OFF_PB_CTRL][4];
      env_ctl[2].restart = is_wr && (off == OFF_NS_LEN) && enables[CH_NS] &&
                           !regs_ff[OFF_NS_CTRL][4];
      for (int e = 0; e < NUM_ENV; e++) begin
         env_ctl[e].quarter = is_quarter;
      end
   end

   apuel_env u_env_pa (
      .clock     (clock),
      .reset     (reset),
      .ctrl_reg  (regs_in[OFF_PA_CTRL]),
      .ctl       (env_ctl[0]),
      .level_out (env_level[0])
   );

   apuel_env u_env_pb (
      .clock     (clock),
      .reset     (reset),
      .ctrl_reg  (regs_in[OFF_PB_CTRL]),
      .ctl       (env_ctl[1]),
      .level_out (env_level[1])
   );

   apuel_env u_env_ns (
      .clock     (clock),
      .reset     (reset),
      .ctrl_reg  (regs_in[OFF_NS_CTRL]),
      .ctl       (env_ctl[2]),
      .level_out (env_level[2])
   );

   // Length and linear counter control.
   always_comb begin
      len_ctl.load       = {is_wr && (off == OFF_NS_LEN), is_wr && (off == OFF_TRI_LEN),
                            is_wr && (off == OFF_PB_LEN), is_wr && (off == OFF_PA_LEN)};
      len_ctl.load_val   = LEN_TABLE[wdata[7:3]];
      len_ctl.status_wr  = is_wr && (off == OFF_STATUS);
      len_ctl.status_val = wdata[4:0];
      len_ctl.half       = is_half;
      len_ctl.halt       = {regs_ff[OFF_NS_CTRL][5], regs_ff[OFF_TRI_LIN][7],
                            regs_ff[OFF_PB_CTRL][5], regs_ff[OFF_PA_CTRL][5]};
      len_ctl.tri_ctrl   = regs_ff[OFF_TRI_LIN][7];
      len_ctl.lin_reload = regs_ff[OFF_TRI_LIN][6:0];
      len_ctl.lin_set    = is_wr && (off == OFF_TRI_LEN);
   end

   apuel_len u_len (
      .clock        (clock),
      .reset        (reset),
      .ctl          (len_ctl),
      .enables      (enables),
      .active_flags (active_flags),
      .linear       (linear)
   );

   // Result register.
   always_comb begin
      rsp_in.rdata           = is_rd ? regs_ff[off] : 8'd0;
      rsp_in.pulse_a_level   = env_level[0];
      rsp_in.pulse_b_level   = env_level[1];
      rsp_in.noise_level     = env_level[2];
      rsp_in.active_flags    = active_flags;
      rsp_in.triangle_linear = linear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= req_vld_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Every accepted beat gives a result once it has passed the input and result registers.
   a_beat_to_result: assert property (@(posedge clock) disable iff (reset)
      start |=> ##1 rsp_valid)
      else $error("accepted beat produced no result");

   // No result appears without a matching earlier beat on start.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2))
      else $error("result without a beat");

   // The linear counter never goes past its reload maximum.
   a_linear_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.triangle_linear <= 8'd128)
      else $error("linear counter out of range");

   // Triangle active needs a running linear counter.
   a_tri_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.active_flags[2] |-> rsp_data.triangle_linear != 8'd0)
      else $error("triangle active with linear counter at zero");
`endif

endmodule

`default_nettype wire
